// ----- rtl/dual_window_history_ring_assert.svh -----
// Assertion macros for the dual window history ring checks.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef DUAL_WINDOW_HISTORY_RING_ASSERT_SVH
`define DUAL_WINDOW_HISTORY_RING_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DWHR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dual window history ring check failed");

// Next-cycle implication, disabled during reset
`define DWHR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dual window history ring check failed");

`endif

// ----- rtl/dwhr_pkg.sv -----
// Shared constants and types for the dual window history ring.
// No dependencies; used by every RTL file of the block but dwhr_ram and the assertion header.
package dwhr_pkg;

    // Field widths fixed by the interface
    localparam int WORD_BITS  = 64;
    localparam int MODE_BITS  = 2;
    localparam int INDEX_BITS = 8;
    localparam int COUNT_BITS = 9;
    localparam int DIV_BITS   = 8;

    // Operation codes
    localparam logic [MODE_BITS-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

    // Reset value of the slow ring divisor
    localparam logic [DIV_BITS-1:0] DIV_RESET = 8'd10;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Per-operation control passed from front to back
    typedef struct packed {
        logic                  fast_wr;
        logic                  slow_wr;
        logic                  rd;
        logic                  window;
        logic                  found;
        logic [COUNT_BITS-1:0] count;
    } op_ctrl_t;

endpackage

// ----- rtl/dwhr_if.sv -----
// Valid/ready channel interfaces for input items, results and config writes.
// Depends on dwhr_pkg for field widths.
interface dwhr_in_if;
    import dwhr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [MODE_BITS-1:0]  mode;
    logic [WORD_BITS-1:0]  sample_word;
    logic                  window;
    logic [INDEX_BITS-1:0] entry_index;

    modport source (output valid, mode, sample_word, window, entry_index, input ready);
    modport sink   (input valid, mode, sample_word, window, entry_index, output ready);
endinterface

interface dwhr_out_if;
    import dwhr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [WORD_BITS-1:0]  read_data;
    logic                  found;
    logic [COUNT_BITS-1:0] entry_count;

    modport source (output valid, read_data, found, entry_count, input ready);
    modport sink   (input valid, read_data, found, entry_count, output ready);
endinterface

interface dwhr_cfg_if;
    import dwhr_pkg::*;
    logic                valid;
    logic                ready;
    logic [DIV_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/dwhr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/dwhr_queue.sv -----
// Short register FIFO between the front and back parts.
// Depends on dwhr_pkg for its depth.
module dwhr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import dwhr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != (PW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dwhr_front.sv -----
// Front part: takes input transfers, keeps heads, fill counts and the
// decimation count, and issues memory operations. Depends on dwhr_pkg.
module dwhr_front #(
    parameter int FAST_DEPTH  = 256,
    parameter int SLOW_DEPTH  = 256,
    parameter int SAMPLE_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dwhr_pkg::MODE_BITS-1:0]  mode,
    input  logic [dwhr_pkg::WORD_BITS-1:0]  sample_word,
    input  logic                            window,
    input  logic [dwhr_pkg::INDEX_BITS-1:0] entry_index,
    input  logic [dwhr_pkg::DIV_BITS-1:0]   slow_divisor,
    input  logic                            q_ready,
    output logic                            q_push,
    output dwhr_pkg::op_ctrl_t              q_ctrl,
    output logic [$clog2(FAST_DEPTH)-1:0]   q_fast_addr,
    output logic [$clog2(SLOW_DEPTH)-1:0]   q_slow_addr,
    output logic [SAMPLE_BITS-1:0]          q_data
);
    import dwhr_pkg::*;

    localparam int FAW = $clog2(FAST_DEPTH);
    localparam int SAW = $clog2(SLOW_DEPTH);
    localparam int FFW = $clog2(FAST_DEPTH + 1);
    localparam int SFW = $clog2(SLOW_DEPTH + 1);
    localparam int FTW = $clog2(2 * FAST_DEPTH + (1 << INDEX_BITS));
    localparam int STW = $clog2(2 * SLOW_DEPTH + (1 << INDEX_BITS));

    logic [FAW-1:0]      fast_head_reg, fast_head_next, fast_head_inc;
    logic [FFW-1:0]      fast_fill_reg, fast_fill_next, fast_fill_inc;
    logic [SAW-1:0]      slow_head_reg, slow_head_next, slow_head_inc;
    logic [SFW-1:0]      slow_fill_reg, slow_fill_next, slow_fill_inc;
    logic [DIV_BITS-1:0] dec_count_reg, dec_count_next;
    logic [DIV_BITS:0]   dec_inc;
    logic                slow_hit;
    logic [FTW-1:0]      fast_sum;
    logic [STW-1:0]      slow_sum;
    logic [FAW-1:0]      fast_rd_addr;
    logic [SAW-1:0]      slow_rd_addr;
    logic                fast_found, slow_found;
    logic                accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign q_push   = accept;

    // Ring pointer increments with wrap and saturating fills
    assign fast_head_inc = (fast_head_reg == FAW'(FAST_DEPTH-1)) ? '0 : fast_head_reg + 1'b1;
    assign slow_head_inc = (slow_head_reg == SAW'(SLOW_DEPTH-1)) ? '0 : slow_head_reg + 1'b1;
    assign fast_fill_inc = (fast_fill_reg == FFW'(FAST_DEPTH)) ? fast_fill_reg
                                                               : fast_fill_reg + 1'b1;
    assign slow_fill_inc = (slow_fill_reg == SFW'(SLOW_DEPTH)) ? slow_fill_reg
                                                               : slow_fill_reg + 1'b1;

    // Decimation: every slow_divisor-th push also lands in the slow ring
    assign dec_inc  = {1'b0, dec_count_reg} + (DIV_BITS+1)'(1);
    assign slow_hit = (dec_inc >= {1'b0, slow_divisor});

    // Read address: head - fill + index, folded once into the ring
    assign fast_found = (FTW'(entry_index) < FTW'(fast_fill_reg));
    assign slow_found = (STW'(entry_index) < STW'(slow_fill_reg));
    assign fast_sum   = FTW'(fast_head_reg) + FTW'(FAST_DEPTH) + FTW'(entry_index)
                        - FTW'(fast_fill_reg);
    assign slow_sum   = STW'(slow_head_reg) + STW'(SLOW_DEPTH) + STW'(entry_index)
                        - STW'(slow_fill_reg);
    assign fast_rd_addr = (fast_sum >= FTW'(FAST_DEPTH)) ? FAW'(fast_sum - FTW'(FAST_DEPTH))
                                                         : FAW'(fast_sum);
    assign slow_rd_addr = (slow_sum >= STW'(SLOW_DEPTH)) ? SAW'(slow_sum - STW'(SLOW_DEPTH))
                                                         : SAW'(slow_sum);

    // Classify the item and work out the next ring state
    always_comb
    begin
        fast_head_next = fast_head_reg;
        fast_fill_next = fast_fill_reg;
        slow_head_next = slow_head_reg;
        slow_fill_next = slow_fill_reg;
        dec_count_next = dec_count_reg;
        q_ctrl         = '0;
        q_ctrl.window  = window;
        q_fast_addr    = fast_head_reg;
        q_slow_addr    = slow_head_reg;
        q_data         = SAMPLE_BITS'(sample_word);
        case (mode)
            MODE_PUSH:
            begin
                q_ctrl.fast_wr = 1'b1;
                fast_head_next = fast_head_inc;
                fast_fill_next = fast_fill_inc;
                if (slow_hit)
                begin
                    q_ctrl.slow_wr = 1'b1;
                    slow_head_next = slow_head_inc;
                    slow_fill_next = slow_fill_inc;
                    dec_count_next = '0;
                end
                else
                begin
                    dec_count_next = dec_inc[DIV_BITS-1:0];
                end
            end
            MODE_READ:
            begin
                q_ctrl.found = window ? slow_found : fast_found;
                q_ctrl.rd    = q_ctrl.found;
                q_fast_addr  = fast_rd_addr;
                q_slow_addr  = slow_rd_addr;
            end
            MODE_CLEAR:
            begin
                fast_head_next = '0;
                fast_fill_next = '0;
                slow_head_next = '0;
                slow_fill_next = '0;
                dec_count_next = '0;
            end
            default:
            begin
                // spare code: no state change
            end
        endcase
        q_ctrl.count = window ? COUNT_BITS'(slow_fill_next) : COUNT_BITS'(fast_fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_head_reg <= '0;
            fast_fill_reg <= '0;
            slow_head_reg <= '0;
            slow_fill_reg <= '0;
            dec_count_reg <= '0;
        end
        else if (accept)
        begin
            fast_head_reg <= fast_head_next;
            fast_fill_reg <= fast_fill_next;
            slow_head_reg <= slow_head_next;
            slow_fill_reg <= slow_fill_next;
            dec_count_reg <= dec_count_next;
        end
    end

endmodule

// ----- rtl/dwhr_back.sv -----
// Back part: carries out ring writes and reads on the two stores and
// drives the result register. Depends on dwhr_pkg and dwhr_ram.
module dwhr_back #(
    parameter int FAST_DEPTH  = 256,
    parameter int SLOW_DEPTH  = 256,
    parameter int SAMPLE_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  dwhr_pkg::op_ctrl_t              q_ctrl,
    input  logic [$clog2(FAST_DEPTH)-1:0]   q_fast_addr,
    input  logic [$clog2(SLOW_DEPTH)-1:0]   q_slow_addr,
    input  logic [SAMPLE_BITS-1:0]          q_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dwhr_pkg::WORD_BITS-1:0]  read_data,
    output logic                            found,
    output logic [dwhr_pkg::COUNT_BITS-1:0] entry_count
);
    import dwhr_pkg::*;

    logic                   mem_valid_reg;
    op_ctrl_t               mem_ctrl_reg;
    logic                   mem_adv;
    logic [SAMPLE_BITS-1:0] fast_rd_data, slow_rd_data, sel_data;
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   out_data_reg;
    logic                   out_found_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;

    // Memory stage moves on when the result register is free or draining
    assign mem_adv = mem_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop   = q_valid && (!mem_valid_reg || mem_adv);

    dwhr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (FAST_DEPTH)
    ) u_fast_ram (
        .clk     (clk),
        .wr_en   (q_pop && q_ctrl.fast_wr),
        .wr_addr (q_fast_addr),
        .wr_data (q_data),
        .rd_en   (q_pop && q_ctrl.rd && !q_ctrl.window),
        .rd_addr (q_fast_addr),
        .rd_data (fast_rd_data)
    );

    dwhr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SLOW_DEPTH)
    ) u_slow_ram (
        .clk     (clk),
        .wr_en   (q_pop && q_ctrl.slow_wr),
        .wr_addr (q_slow_addr),
        .wr_data (q_data),
        .rd_en   (q_pop && q_ctrl.rd && q_ctrl.window),
        .rd_addr (q_slow_addr),
        .rd_data (slow_rd_data)
    );

    // Misses and non-read operations return zero
    assign sel_data = !mem_ctrl_reg.found ? '0
                    : (mem_ctrl_reg.window ? slow_rd_data : fast_rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mem_valid_reg <= 1'b1;
            end
            else if (mem_adv)
            begin
                mem_valid_reg <= 1'b0;
            end
            if (mem_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mem_ctrl_reg <= q_ctrl;
        end
        if (mem_adv)
        begin
            out_data_reg  <= WORD_BITS'(sel_data);
            out_found_reg <= mem_ctrl_reg.found;
            out_count_reg <= mem_ctrl_reg.count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign found       = out_found_reg;
    assign entry_count = out_count_reg;

endmodule

// ----- rtl/dual_window_history_ring.sv -----
// Top level of the dual window history ring; holds the divisor register.
// Depends on dwhr_pkg, dwhr_if, dwhr_front, dwhr_queue and dwhr_back.
//
// Two overwrite-oldest histories of sample words: every push goes to the
// fast ring, every slow_divisor-th push also to the slow ring. Each input
// transfer (push, read, clear) gives exactly one result. Items are taken one
// per clock cycle while the output is not back-pressured; each result passes
// through the queue, the registered read of the ring memories and the output
// register. A four-entry queue separates the pointer logic from the memory
// stage, so input is refused only when that queue is full under output
// back-pressure. The stores are not cleared on reset or on clear; there is
// no clearing pass, and reads only reach entries written since the last
// clear. The divisor register is written through the config channel, which
// is always ready, and should be written only while the block is idle.
module dual_window_history_ring #(
    parameter int FAST_DEPTH  = 256,
    parameter int SLOW_DEPTH  = 256,
    parameter int SAMPLE_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    dwhr_in_if.sink    in_ch,
    dwhr_out_if.source out_ch,
    dwhr_cfg_if.sink   cfg_ch
);
    import dwhr_pkg::*;

    localparam int FAW = $clog2(FAST_DEPTH);
    localparam int SAW = $clog2(SLOW_DEPTH);
    localparam int QW  = $bits(op_ctrl_t) + FAW + SAW + SAMPLE_BITS;

    logic [DIV_BITS-1:0]    slow_divisor_reg;
    logic                   q_ready, q_push, q_valid, q_pop;
    op_ctrl_t               f_ctrl, b_ctrl;
    logic [FAW-1:0]         f_fast_addr, b_fast_addr;
    logic [SAW-1:0]         f_slow_addr, b_slow_addr;
    logic [SAMPLE_BITS-1:0] f_data, b_data;
    logic [QW-1:0]          q_in, q_out;

    // Divisor register, written on a config transfer
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_divisor_reg <= DIV_RESET;
        end
        else if (cfg_ch.valid)
        begin
            slow_divisor_reg <= cfg_ch.data;
        end
    end

    dwhr_front #(
        .FAST_DEPTH  (FAST_DEPTH),
        .SLOW_DEPTH  (SLOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .mode         (in_ch.mode),
        .sample_word  (in_ch.sample_word),
        .window       (in_ch.window),
        .entry_index  (in_ch.entry_index),
        .slow_divisor (slow_divisor_reg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_ctrl       (f_ctrl),
        .q_fast_addr  (f_fast_addr),
        .q_slow_addr  (f_slow_addr),
        .q_data       (f_data)
    );

    // Queue payload packing
    assign q_in = {f_ctrl, f_fast_addr, f_slow_addr, f_data};
    assign {b_ctrl, b_fast_addr, b_slow_addr, b_data} = q_out;

    dwhr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_ready (q_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_out)
    );

    dwhr_back #(
        .FAST_DEPTH  (FAST_DEPTH),
        .SLOW_DEPTH  (SLOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_ctrl      (b_ctrl),
        .q_fast_addr (b_fast_addr),
        .q_slow_addr (b_slow_addr),
        .q_data      (b_data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .read_data   (out_ch.read_data),
        .found       (out_ch.found),
        .entry_count (out_ch.entry_count)
    );

endmodule

// ----- rtl/dwhr_checker.sv -----
// Port-level checks for the dual window history ring, bound to the top level.
// Depends on dwhr_pkg and dual_window_history_ring_assert.svh.
`include "dual_window_history_ring_assert.svh"

module dwhr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [dwhr_pkg::WORD_BITS-1:0]  read_data,
    input logic                            found,
    input logic [dwhr_pkg::COUNT_BITS-1:0] entry_count
);
    import dwhr_pkg::*;

    logic                             out_stall;
    logic [WORD_BITS+COUNT_BITS:0]    out_payload;

    assign out_stall   = out_valid && !out_ready;
    assign out_payload = {read_data, found, entry_count};

    // A stalled result stays put
    `DWHR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))

    // A miss or a non-read never carries data
    `DWHR_ASSERT_NOW(a_miss_zero, out_valid && !found, read_data == '0)

    // Input is only refused while a result is waiting downstream
    `DWHR_ASSERT_NOW(a_refuse_pending, !in_ready, out_valid)

endmodule

bind dual_window_history_ring dwhr_checker u_dwhr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .read_data   (out_ch.read_data),
    .found       (out_ch.found),
    .entry_count (out_ch.entry_count)
);
